[sv/kss_pkg.sv]
// Package for the keyed sorted score table: widths, codes, word layouts and helpers.
// Used by kss_cell and keyed_sorted_score_table_core; no dependencies.
package kss_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 64;
    localparam int SCORE_W  = 32;
    localparam int RANK_W   = 6;
    localparam int CMP_W    = (RANK_W > CNT_W) ? RANK_W : CNT_W;

    localparam int IN_BITS  = 1 + KEY_W + SCORE_W + RANK_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + KEY_W + SCORE_W + RANK_W + 3;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_RAISED    = 3'd1,
        ST_UNCHANGED = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_READ      = 3'd4
    } t_status;

    typedef enum logic {
        ACT_SUBMIT = 1'b0,
        ACT_READ   = 1'b1
    } t_action;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } t_state;

    typedef struct packed {
        logic load_new;
        logic shift_in;
    } t_cell_ctl;

    function automatic logic [IDX_W-1:0] onehot_idx(input logic [CAPACITY-1:0] oh);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (oh[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[sv/kss_cell.sv]
// One slot of the sorted table: key, score, valid and the registered lookup flags.
// Depends on kss_pkg; chained by keyed_sorted_score_table_core.
module kss_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_capture,
    input  logic [kss_pkg::KEY_W-1:0]     i_cmp_key,
    input  logic [kss_pkg::SCORE_W-1:0]   i_cmp_score,
    input  kss_pkg::t_cell_ctl            i_ctl,
    input  logic [kss_pkg::KEY_W-1:0]     i_prev_key,
    input  logic [kss_pkg::SCORE_W-1:0]   i_prev_score,
    output logic [kss_pkg::KEY_W-1:0]     o_key,
    output logic [kss_pkg::SCORE_W-1:0]   o_score,
    output logic                          o_valid,
    output logic                          o_match,
    output logic                          o_gt
);

    logic [kss_pkg::KEY_W-1:0]   r_key;
    logic [kss_pkg::SCORE_W-1:0] r_score;
    logic                        r_valid;
    logic                        r_match;
    logic                        r_gt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load_new || i_ctl.shift_in) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_new) begin
            r_key   <= i_cmp_key;
            r_score <= i_cmp_score;
        end else if (i_ctl.shift_in) begin
            r_key   <= i_prev_key;
            r_score <= i_prev_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_match <= r_valid && (r_key == i_cmp_key);
            r_gt    <= r_valid && ($signed(r_score) > $signed(i_cmp_score));
        end
    end

    assign o_key   = r_key;
    assign o_score = r_score;
    assign o_valid = r_valid;
    assign o_match = r_match;
    assign o_gt    = r_gt;

endmodule

[sv/keyed_sorted_score_table_core.sv]
// Top level of the keyed sorted score table: stream ports, control and the chain of cells.
// Depends on kss_pkg and kss_cell.
//
//  channel   | dir | fields (tdata, low bit first)
//  s_axis    | in  | action, user_key, new_score, read_rank
//  m_axis    | out | entry_valid, entry_key, entry_score, entry_rank, status
//
// Each item has an accept cycle, which compares key and score in every cell at once,
// and an apply cycle, which moves entries one place along the chain and loads the
// result word. The apply cycle waits while the output register holds an untaken word.
// Synchronous active-low reset empties the table.
module keyed_sorted_score_table_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // action[0], user_key[64:1], new_score[96:65], read_rank[102:97]
    input  logic [kss_pkg::IN_W-1:0]    i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // entry_valid[0], entry_key[64:1], entry_score[96:65], entry_rank[102:97],
    // status[105:103]
    output logic [kss_pkg::OUT_W-1:0]   o_m_tdata
);

    localparam int CAP = kss_pkg::CAPACITY;

    kss_pkg::t_state                r_state;
    kss_pkg::t_state                n_state;
    logic                           w_accept;
    logic                           w_apply;

    kss_pkg::t_action               r_act;
    logic [kss_pkg::KEY_W-1:0]      r_key;
    logic [kss_pkg::SCORE_W-1:0]    r_score;
    logic [kss_pkg::RANK_W-1:0]     r_rank;
    logic [kss_pkg::CNT_W-1:0]      r_count;
    logic [kss_pkg::CNT_W-1:0]      n_count;

    logic                           r_out_valid;
    logic [kss_pkg::OUT_W-1:0]      r_out_data;
    logic [kss_pkg::OUT_W-1:0]      n_out_data;

    logic [kss_pkg::KEY_W-1:0]      w_cell_key   [CAP];
    logic [kss_pkg::SCORE_W-1:0]    w_cell_score [CAP];
    logic [CAP-1:0]                 w_valid;
    logic [CAP-1:0]                 w_match;
    logic [CAP-1:0]                 w_gt;
    logic [CAP-1:0]                 w_bound;
    logic [CAP-1:0]                 w_rd_sel;
    kss_pkg::t_cell_ctl             w_ctl [CAP];

    logic [kss_pkg::IDX_W-1:0]      w_f_idx;
    logic [kss_pkg::IDX_W-1:0]      w_p_idx;
    logic [kss_pkg::IDX_W-1:0]      w_e_idx;
    logic                           w_any_match;
    logic                           w_full;
    logic                           w_raise;
    logic                           w_insert;
    logic                           w_write;
    logic                           w_rd_hit;
    logic [kss_pkg::SCORE_W-1:0]    w_score_f;
    logic [kss_pkg::KEY_W-1:0]      w_rd_key;
    logic [kss_pkg::SCORE_W-1:0]    w_rd_score;

    logic                           w_res_valid;
    logic [kss_pkg::KEY_W-1:0]      w_res_key;
    logic [kss_pkg::SCORE_W-1:0]    w_res_score;
    logic [kss_pkg::RANK_W-1:0]     w_res_rank;
    kss_pkg::t_status               w_res_status;

    // state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            kss_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = kss_pkg::S_APPLY;
                end
            end
            kss_pkg::S_APPLY: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = kss_pkg::S_IDLE;
                end
            end
            default: n_state = kss_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_apply    = 1'b0;
        case (r_state)
            kss_pkg::S_IDLE:  o_s_tready = 1'b1;
            kss_pkg::S_APPLY: w_apply    = !r_out_valid || i_m_tready;
            default: begin
                o_s_tready = 1'b0;
                w_apply    = 1'b0;
            end
        endcase
    end

    assign w_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kss_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act   <= kss_pkg::t_action'(i_s_tdata[0]);
            r_key   <= i_s_tdata[64:1];
            r_score <= i_s_tdata[96:65];
            r_rank  <= i_s_tdata[102:97];
        end
    end

    // chain of cells
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        logic [kss_pkg::KEY_W-1:0]   w_prev_key;
        logic [kss_pkg::SCORE_W-1:0] w_prev_score;

        if (i == 0) begin : g_head
            assign w_prev_key   = '0;
            assign w_prev_score = '0;
            assign w_bound[i]   = !w_gt[i];
        end else begin : g_body
            assign w_prev_key   = w_cell_key[i-1];
            assign w_prev_score = w_cell_score[i-1];
            assign w_bound[i]   = !w_gt[i] && w_gt[i-1];
        end

        assign w_ctl[i].load_new = w_write && (kss_pkg::IDX_W'(i) == w_p_idx);
        assign w_ctl[i].shift_in = w_write && (kss_pkg::IDX_W'(i) > w_p_idx)
                                   && (kss_pkg::IDX_W'(i) <= w_e_idx);
        assign w_rd_sel[i] = (kss_pkg::CMP_W'(r_rank) == kss_pkg::CMP_W'(i));

        kss_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_capture    (w_accept),
            .i_cmp_key    (w_accept ? i_s_tdata[64:1]  : r_key),
            .i_cmp_score  (w_accept ? i_s_tdata[96:65] : r_score),
            .i_ctl        (w_ctl[i]),
            .i_prev_key   (w_prev_key),
            .i_prev_score (w_prev_score),
            .o_key        (w_cell_key[i]),
            .o_score      (w_cell_score[i]),
            .o_valid      (w_valid[i]),
            .o_match      (w_match[i]),
            .o_gt         (w_gt[i])
        );
    end

    // selection of stored entries
    always_comb begin
        w_score_f  = '0;
        w_rd_key   = '0;
        w_rd_score = '0;
        for (int i = 0; i < CAP; i++) begin
            if (w_match[i]) begin
                w_score_f = w_score_f | w_cell_score[i];
            end
            if (w_rd_sel[i] && w_valid[i]) begin
                w_rd_key   = w_rd_key | w_cell_key[i];
                w_rd_score = w_rd_score | w_cell_score[i];
            end
        end
    end

    assign w_f_idx     = kss_pkg::onehot_idx(w_match);
    assign w_p_idx     = kss_pkg::onehot_idx(w_bound);
    assign w_any_match = |w_match;
    assign w_full      = (r_count == kss_pkg::CNT_W'(CAP));
    assign w_rd_hit    = kss_pkg::CMP_W'(r_rank) < kss_pkg::CMP_W'(r_count);

    assign w_raise  = (r_act == kss_pkg::ACT_SUBMIT) && w_any_match
                      && ($signed(r_score) > $signed(w_score_f));
    assign w_insert = (r_act == kss_pkg::ACT_SUBMIT) && !w_any_match
                      && !(w_full && w_gt[CAP-1]);
    assign w_write  = w_apply && (w_raise || w_insert);

    always_comb begin
        if (w_raise) begin
            w_e_idx = w_f_idx;
        end else if (w_full) begin
            w_e_idx = kss_pkg::IDX_W'(CAP - 1);
        end else begin
            w_e_idx = kss_pkg::IDX_W'(r_count);
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_apply && w_insert && !w_full) begin
            n_count = r_count + kss_pkg::CNT_W'(1);
        end
    end

    // result word
    always_comb begin
        if (r_act == kss_pkg::ACT_READ) begin
            w_res_valid  = w_rd_hit;
            w_res_key    = w_rd_hit ? w_rd_key : '0;
            w_res_score  = w_rd_hit ? w_rd_score : '0;
            w_res_rank   = r_rank;
            w_res_status = kss_pkg::ST_READ;
        end else if (w_any_match) begin
            w_res_valid  = 1'b1;
            w_res_key    = r_key;
            if (w_raise) begin
                w_res_score  = r_score;
                w_res_rank   = kss_pkg::RANK_W'(w_p_idx);
                w_res_status = kss_pkg::ST_RAISED;
            end else begin
                w_res_score  = w_score_f;
                w_res_rank   = kss_pkg::RANK_W'(w_f_idx);
                w_res_status = kss_pkg::ST_UNCHANGED;
            end
        end else if (w_insert) begin
            w_res_valid  = 1'b1;
            w_res_key    = r_key;
            w_res_score  = r_score;
            w_res_rank   = kss_pkg::RANK_W'(w_p_idx);
            w_res_status = kss_pkg::ST_INSERTED;
        end else begin
            w_res_valid  = 1'b0;
            w_res_key    = r_key;
            w_res_score  = r_score;
            w_res_rank   = '0;
            w_res_status = kss_pkg::ST_DROPPED;
        end
    end

    assign n_out_data = kss_pkg::OUT_W'({w_res_status, w_res_rank, w_res_score,
                                         w_res_key, w_res_valid});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[test/tb.sv]
// Testbench for keyed_sorted_score_table_core: stream driver, random backpressure and a
// scoreboard that keeps its own sorted copy of the table to predict every result word.
// Depends on kss_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [kss_pkg::RANK_W-1:0]  rank;
        logic [kss_pkg::SCORE_W-1:0] score;
        logic [kss_pkg::KEY_W-1:0]   key;
        kss_pkg::t_action            action;
    } t_submit;

    typedef struct packed {
        kss_pkg::t_status            status;
        logic [kss_pkg::RANK_W-1:0]  rank;
        logic [kss_pkg::SCORE_W-1:0] score;
        logic [kss_pkg::KEY_W-1:0]   key;
        logic                        valid;
    } t_result;

    class score_table_sb;
        logic [kss_pkg::KEY_W-1:0]   keys   [kss_pkg::CAPACITY];
        logic [kss_pkg::SCORE_W-1:0] scores [kss_pkg::CAPACITY];
        int                          count;
        int                          errors;
        t_result                     result_q [$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int place(logic [kss_pkg::KEY_W-1:0] key, logic [kss_pkg::SCORE_W-1:0] score);
            int p;
            p = 0;
            while (p < count && $signed(scores[p]) > $signed(score)) begin
                p++;
            end
            for (int i = count; i > p; i--) begin
                keys[i]   = keys[i-1];
                scores[i] = scores[i-1];
            end
            keys[p]   = key;
            scores[p] = score;
            count++;
            return p;
        endfunction

        function void note_input(t_submit w);
            t_result r;
            int      f;
            int      p;
            r = '0;
            if (w.action == kss_pkg::ACT_READ) begin
                r.status = kss_pkg::ST_READ;
                r.rank   = w.rank;
                if (int'(w.rank) < count) begin
                    r.valid = 1'b1;
                    r.key   = keys[w.rank];
                    r.score = scores[w.rank];
                end
            end else begin
                f = 0;
                while (f < count && keys[f] != w.key) begin
                    f++;
                end
                if (f < count) begin
                    if ($signed(w.score) > $signed(scores[f])) begin
                        for (int i = f; i + 1 < count; i++) begin
                            keys[i]   = keys[i+1];
                            scores[i] = scores[i+1];
                        end
                        count--;
                        p        = place(w.key, w.score);
                        r.status = kss_pkg::ST_RAISED;
                        r.valid  = 1'b1;
                        r.key    = w.key;
                        r.score  = w.score;
                        r.rank   = kss_pkg::RANK_W'(p);
                    end else begin
                        r.status = kss_pkg::ST_UNCHANGED;
                        r.valid  = 1'b1;
                        r.key    = w.key;
                        r.score  = scores[f];
                        r.rank   = kss_pkg::RANK_W'(f);
                    end
                end else if (count >= kss_pkg::CAPACITY &&
                             $signed(w.score) < $signed(scores[count-1])) begin
                    r.status = kss_pkg::ST_DROPPED;
                    r.key    = w.key;
                    r.score  = w.score;
                end else begin
                    if (count >= kss_pkg::CAPACITY) begin
                        count--;
                    end
                    p        = place(w.key, w.score);
                    r.status = kss_pkg::ST_INSERTED;
                    r.valid  = 1'b1;
                    r.key    = w.key;
                    r.score  = w.score;
                    r.rank   = kss_pkg::RANK_W'(p);
                end
            end
            result_q.push_back(r);
        endfunction

        function void check_result(logic [kss_pkg::OUT_W-1:0] word);
            t_result got;
            t_result want;
            got = t_result'(word[kss_pkg::OUT_BITS-1:0]);
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, word);
                errors++;
                return;
            end
            want = result_q.pop_front();
            if (got.valid !== want.valid) begin
                $display("%0t: entry_valid expected %0d actual %0d", $time, want.valid, got.valid);
                errors++;
            end
            if (got.key !== want.key) begin
                $display("%0t: entry_key expected %h actual %h", $time, want.key, got.key);
                errors++;
            end
            if (got.score !== want.score) begin
                $display("%0t: entry_score expected %h actual %h", $time, want.score, got.score);
                errors++;
            end
            if (got.rank !== want.rank) begin
                $display("%0t: entry_rank expected %0d actual %0d", $time, want.rank, got.rank);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [kss_pkg::IN_W-1:0]        i_s_tdata  = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [kss_pkg::OUT_W-1:0]       o_m_tdata;

    int                              send_idle_pct = 26;
    int                              recv_idle_pct = 49;
    logic [kss_pkg::KEY_W-1:0]       key_pool [96];
    score_table_sb                   sb = new();

    keyed_sorted_score_table_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
        end
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(kss_pkg::t_action act, logic [kss_pkg::KEY_W-1:0] key,
                             logic [kss_pkg::SCORE_W-1:0] score,
                             logic [kss_pkg::RANK_W-1:0] rank);
        t_submit w;
        w.action = act;
        w.key    = key;
        w.score  = score;
        w.rank   = rank;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= kss_pkg::IN_W'(w);
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        sb.note_input(w);
    endtask

    initial begin
        logic [kss_pkg::KEY_W-1:0]   key;
        logic [kss_pkg::SCORE_W-1:0] score;
        kss_pkg::t_action            act;
        for (int i = 0; i < 96; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table reads, extreme keys and scores, ties, raises
        send_item(kss_pkg::ACT_READ,   64'h0123_4567_89ab_cdef, 32'hffff_ffff, 6'd0);
        send_item(kss_pkg::ACT_READ,   '1, '1, 6'd63);
        send_item(kss_pkg::ACT_SUBMIT, '0, '0, 6'd63);
        send_item(kss_pkg::ACT_SUBMIT, '1, 32'h7fff_ffff, 6'd0);
        send_item(kss_pkg::ACT_SUBMIT, key_pool[2], 32'h8000_0000, 6'd21);
        send_item(kss_pkg::ACT_SUBMIT, key_pool[3], '0, 6'd0);
        send_item(kss_pkg::ACT_SUBMIT, '0, '0, 6'd5);
        send_item(kss_pkg::ACT_SUBMIT, '0, 32'hffff_fffb, 6'd0);
        send_item(kss_pkg::ACT_SUBMIT, key_pool[2], 32'd100, 6'd0);
        send_item(kss_pkg::ACT_SUBMIT, key_pool[3], 32'h7fff_ffff, 6'd0);
        send_item(kss_pkg::ACT_SUBMIT, '1, 32'h7fff_fffe, 6'd0);
        send_item(kss_pkg::ACT_SUBMIT, key_pool[4], 32'h8000_0000, 6'd42);
        for (int r = 0; r < 6; r++) begin
            send_item(kss_pkg::ACT_READ, {$urandom, $urandom}, $urandom,
                      kss_pkg::RANK_W'(r));
        end
        send_item(kss_pkg::ACT_READ, '0, '0, 6'd63);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 49;
                end
                1: begin
                    send_idle_pct = 49;
                    recv_idle_pct = 26;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 650; n++) begin
                act = ($urandom_range(0, 3) == 0) ? kss_pkg::ACT_READ : kss_pkg::ACT_SUBMIT;
                if ($urandom_range(0, 9) < 7) begin
                    key = key_pool[$urandom_range(0, 95)];
                end else begin
                    key = {$urandom, $urandom};
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: score = 32'($urandom_range(0, 40)) - 32'd20;
                    4: begin
                        case ($urandom_range(0, 3))
                            0:       score = 32'h8000_0000;
                            1:       score = 32'h7fff_ffff;
                            2:       score = '0;
                            default: score = '1;
                        endcase
                    end
                    default: score = $urandom;
                endcase
                send_item(act, key, score, kss_pkg::RANK_W'($urandom_range(0, 63)));
            end
        end

        i_s_tvalid <= 1'b0;
        while (sb.result_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
